// ----- rtl/sbm_pkg.sv -----
// Shared types and constants for the serial bank mapper.
`default_nettype none
package sbm_pkg;

    localparam int RAM_BYTES = 8192;
    localparam int RAM_AW    = $clog2(RAM_BYTES);

    localparam logic [1:0] ACT_CPU_RD = 2'd0;
    localparam logic [1:0] ACT_CPU_WR = 2'd1;
    localparam logic [1:0] ACT_PPU_RD = 2'd2;
    localparam logic [1:0] ACT_PPU_WR = 2'd3;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_MAPPED = 2'd1;
    localparam logic [1:0] ST_RAM_RD = 2'd2;
    localparam logic [1:0] ST_RAM_WR = 2'd3;

    localparam logic [1:0] SEL_CONTROL = 2'd0;
    localparam logic [1:0] SEL_CHR0    = 2'd1;
    localparam logic [1:0] SEL_CHR1    = 2'd2;
    localparam logic [1:0] SEL_PRG     = 2'd3;

    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  write_byte;
    } t_sbm_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] mapped_address;
        logic [7:0]  read_byte;
        logic [1:0]  mirroring;
    } t_sbm_out;

    // Register-file request for one transaction.
    typedef struct packed {
        logic       cpu_rd;
        logic       ld_we;
        logic [1:0] ld_sel;
        logic       ld_reset;
        logic       ld_bit;
    } t_sbm_req;

    // Mapping state seen by the datapath.
    typedef struct packed {
        logic [17:0] prg_off0;
        logic [17:0] prg_off1;
        logic [16:0] chr_off0;
        logic [16:0] chr_off1;
        logic        ram_en;
        logic [1:0]  mirror_next;
    } t_sbm_map;

endpackage
`default_nettype wire

// ----- rtl/sbm_regs.sv -----
// Serial loader, mapper registers and bank offset state.
`default_nettype none
module sbm_regs (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [4:0]       i_cfg_wdata,
    input  wire sbm_pkg::t_sbm_req i_req,
    output sbm_pkg::t_sbm_map     o_map
);

    logic [5:0]  r_shift,   n_shift;
    logic [4:0]  r_control, n_control;
    logic [4:0]  r_chr_lo,  n_chr_lo;
    logic [4:0]  r_chr_hi,  n_chr_hi;
    logic [3:0]  r_prg_sel, n_prg_sel;
    logic        r_ram_en,  n_ram_en;
    logic        r_blocked, n_blocked;
    logic [1:0]  r_mirror,  n_mirror;
    logic [4:0]  r_count,   n_count;
    logic [17:0] r_prg_off0, n_prg_off0;
    logic [17:0] r_prg_off1, n_prg_off1;
    logic [16:0] r_chr_off0, n_chr_off0;
    logic [16:0] r_chr_off1, n_chr_off1;

    logic [5:0] shifted;
    logic [4:0] value;
    logic [4:0] count_m1;
    logic [4:0] cfg_m1;

    always_comb begin
        n_shift    = r_shift;
        n_control  = r_control;
        n_chr_lo   = r_chr_lo;
        n_chr_hi   = r_chr_hi;
        n_prg_sel  = r_prg_sel;
        n_ram_en   = r_ram_en;
        n_blocked  = r_blocked;
        n_mirror   = r_mirror;
        n_count    = r_count;
        n_prg_off0 = r_prg_off0;
        n_prg_off1 = r_prg_off1;
        n_chr_off0 = r_chr_off0;
        n_chr_off1 = r_chr_off1;
        shifted    = {i_req.ld_bit, r_shift[5:1]};
        value      = shifted[5:1];
        count_m1   = r_count - 5'd1;
        cfg_m1     = i_cfg_wdata - 5'd1;

        if (i_req.cpu_rd) begin
            n_blocked = 1'b0;
        end

        if (i_req.ld_we && !r_blocked) begin
            if (i_req.ld_reset) begin
                n_shift   = 6'b100000;
                n_control = r_control | 5'h0C;
                n_blocked = 1'b1;
            end else if (!shifted[0]) begin
                n_shift = shifted;
            end else begin
                n_shift = 6'b100000;
                unique case (i_req.ld_sel)
                    sbm_pkg::SEL_CONTROL: begin
                        n_control = value;
                        n_mirror  = value[1:0];
                    end
                    sbm_pkg::SEL_CHR0: n_chr_lo = value;
                    sbm_pkg::SEL_CHR1: n_chr_hi = value;
                    sbm_pkg::SEL_PRG: begin
                        n_prg_sel = value[3:0];
                        n_ram_en  = value[4];
                    end
                    default: n_shift = 6'b100000;
                endcase

                case (n_control[3:2])
                    sbm_pkg::PRG_MODE_FIX_FIRST: begin
                        n_prg_off0 = '0;
                        n_prg_off1 = {n_prg_sel, 14'h0};
                    end
                    sbm_pkg::PRG_MODE_FIX_LAST: begin
                        n_prg_off0 = {n_prg_sel, 14'h0};
                        n_prg_off1 = {count_m1[3:0], 14'h0};
                    end
                    default: begin
                        n_prg_off0 = {n_prg_sel[3:1], 1'b0, 14'h0};
                        n_prg_off1 = {n_prg_sel[3:1], 1'b1, 14'h0};
                    end
                endcase

                if (n_control[4]) begin
                    n_chr_off0 = {n_chr_lo, 12'h0};
                    n_chr_off1 = {n_chr_hi, 12'h0};
                end else begin
                    n_chr_off0 = {n_chr_lo[4:1], 1'b0, 12'h0};
                    n_chr_off1 = {n_chr_lo[4:1], 1'b1, 12'h0};
                end
            end
        end

        if (i_cfg_we) begin
            n_count = i_cfg_wdata;
            if (r_control[3:2] == sbm_pkg::PRG_MODE_FIX_LAST) begin
                n_prg_off1 = {cfg_m1[3:0], 14'h0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift    <= 6'b100000;
            r_control  <= 5'h0C;
            r_chr_lo   <= '0;
            r_chr_hi   <= '0;
            r_prg_sel  <= '0;
            r_ram_en   <= 1'b0;
            r_blocked  <= 1'b0;
            r_mirror   <= '0;
            r_count    <= 5'd2;
            r_prg_off0 <= '0;
            r_prg_off1 <= 18'h04000;
            r_chr_off0 <= '0;
            r_chr_off1 <= 17'h01000;
        end else begin
            r_shift    <= n_shift;
            r_control  <= n_control;
            r_chr_lo   <= n_chr_lo;
            r_chr_hi   <= n_chr_hi;
            r_prg_sel  <= n_prg_sel;
            r_ram_en   <= n_ram_en;
            r_blocked  <= n_blocked;
            r_mirror   <= n_mirror;
            r_count    <= n_count;
            r_prg_off0 <= n_prg_off0;
            r_prg_off1 <= n_prg_off1;
            r_chr_off0 <= n_chr_off0;
            r_chr_off1 <= n_chr_off1;
        end
    end

    assign o_map.prg_off0    = r_prg_off0;
    assign o_map.prg_off1    = r_prg_off1;
    assign o_map.chr_off0    = r_chr_off0;
    assign o_map.chr_off1    = r_chr_off1;
    assign o_map.ram_en      = r_ram_en;
    assign o_map.mirror_next = n_mirror;

endmodule
`default_nettype wire

// ----- rtl/sbm_wram.sv -----
// Work RAM: single port, registered read.
`default_nettype none
module sbm_wram (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic                       i_re,
    input  wire logic [sbm_pkg::RAM_AW-1:0] i_addr,
    input  wire logic [7:0]                 i_wdata,
    output logic [7:0]                      o_rdata
);

    logic [7:0] r_mem [sbm_pkg::RAM_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/serial_bank_mapper_core.sv -----
// Top level of the serial bank mapper.
//
// Input channel i_in_*: one bus access per transaction (cpu read, cpu write,
// ppu read, ppu write). Output channel o_out_*: exactly one result per
// accepted access, in order. i_cfg_we/i_cfg_wdata write the program bank
// count; write it only while no transaction is in flight.
//
// An accepted access lands in an input register. When the result register
// can advance, it is decoded, the loader and bank registers update, the work
// RAM is written or read, and the result register loads; a receiver stall
// holds the access in the input register until then.
// One access per cycle is sustained while the receiver takes every result;
// the work RAM port takes one access per cycle and sets that figure.
//
// When the receiver stalls, the result register holds and the input
// register still takes one more access; o_in_ready drops only when both
// are full. Reset clears both valid flags and returns the loader, control
// and bank registers to their power-on values; work RAM is not cleared.
`default_nettype none
module serial_bank_mapper_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [4:0]        i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire sbm_pkg::t_sbm_in  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output sbm_pkg::t_sbm_out      o_out_data
);

    logic              r_in_valid;
    sbm_pkg::t_sbm_in  r_in;
    logic              r_out_valid;
    logic [1:0]        r_status,  n_status;
    logic [17:0]       r_mapped,  n_mapped;
    logic [1:0]        r_mirror;

    logic              advance;
    logic              take;
    logic              ram_win;
    logic              ram_we;
    logic              ram_re;
    logic [7:0]        ram_rdata;
    sbm_pkg::t_sbm_req req;
    sbm_pkg::t_sbm_map map;

    assign advance    = !r_out_valid || i_out_ready;
    assign take       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;
    assign ram_win    = (r_in.address[15:13] == 3'b011);

    always_comb begin
        req      = '0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        n_status = sbm_pkg::ST_NONE;
        n_mapped = '0;
        unique case (r_in.action)
            sbm_pkg::ACT_CPU_RD: begin
                req.cpu_rd = take;
                if (r_in.address[15]) begin
                    n_status = sbm_pkg::ST_MAPPED;
                    n_mapped = r_in.address[14]
                        ? {map.prg_off1[17:14], r_in.address[13:0]}
                        : {map.prg_off0[17:14], r_in.address[13:0]};
                end else if (map.ram_en && ram_win) begin
                    n_status = sbm_pkg::ST_RAM_RD;
                    ram_re   = take;
                end
            end
            sbm_pkg::ACT_CPU_WR: begin
                if (r_in.address[15]) begin
                    req.ld_we    = take;
                    req.ld_sel   = r_in.address[14:13];
                    req.ld_reset = r_in.write_byte[7];
                    req.ld_bit   = r_in.write_byte[0];
                end else if (ram_win) begin
                    n_status = sbm_pkg::ST_RAM_WR;
                    ram_we   = take;
                end
            end
            sbm_pkg::ACT_PPU_RD: begin
                if (r_in.address[15:13] == 3'b000) begin
                    n_status = sbm_pkg::ST_MAPPED;
                    n_mapped = r_in.address[12]
                        ? {1'b0, map.chr_off1[16:12], r_in.address[11:0]}
                        : {1'b0, map.chr_off0[16:12], r_in.address[11:0]};
                end
            end
            sbm_pkg::ACT_PPU_WR: n_status = sbm_pkg::ST_NONE;
            default:             n_status = sbm_pkg::ST_NONE;
        endcase
    end

    sbm_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req),
        .o_map       (map)
    );

    sbm_wram u_wram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (r_in.address[sbm_pkg::RAM_AW-1:0]),
        .i_wdata (r_in.write_byte),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (take) begin
            r_status <= n_status;
            r_mapped <= n_mapped;
            r_mirror <= map.mirror_next;
        end
    end

    assign o_out_valid               = r_out_valid;
    assign o_out_data.status         = r_status;
    assign o_out_data.mapped_address = r_mapped;
    assign o_out_data.read_byte      = (r_status == sbm_pkg::ST_RAM_RD) ? ram_rdata : 8'h00;
    assign o_out_data.mirroring      = r_mirror;

endmodule
`default_nettype wire

// ----- rtl/sbm_checker.sv -----
// Port-level assertions for the serial bank mapper, bound to the top level.
`default_nettype none
module sbm_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire sbm_pkg::t_sbm_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_addr_only_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != sbm_pkg::ST_MAPPED
            |-> o_out_data.mapped_address == 18'h0)
        else $error("mapped address without mapped status");

    a_byte_only_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != sbm_pkg::ST_RAM_RD
            |-> o_out_data.read_byte == 8'h00)
        else $error("read byte without ram read status");

endmodule

bind serial_bank_mapper_core sbm_checker u_sbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
